>>> rtl/assert_macros.svh
// Assertion helper macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at each clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked during reset too
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/lbo_pkg.sv
// ----------------------------------------------------------------------------
// lbo_pkg
// Types and codes shared by the box order engine.
// ----------------------------------------------------------------------------
package lbo_pkg;

  localparam int unsigned MaxBoxes = 1024;
  localparam int unsigned KindW    = 3;
  localparam int unsigned SumW     = 20;
  localparam int unsigned CountW   = 11;

  typedef enum logic [2:0] {
    KIND_INIT  = 3'd0,
    KIND_LEFT  = 3'd1,
    KIND_RIGHT = 3'd2,
    KIND_SWAP  = 3'd3,
    KIND_REV   = 3'd4,
    KIND_QUERY = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_RD_A,
    ST_RD_B,
    ST_WAIT,
    ST_WR,
    ST_Q_RD,
    ST_Q_STEP,
    ST_Q_FIN
  } state_e;

endpackage

>>> rtl/lbo_link_mem.sv
// ----------------------------------------------------------------------------
// lbo_link_mem
// One link store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lbo_link_mem #(
  parameter int unsigned Depth = 1025,
  parameter int unsigned Width = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/linked_box_order_engine_unit.sv
// ----------------------------------------------------------------------------
// linked_box_order_engine_unit
// Ordered list of boxes kept as left/right link memories with a sentinel.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// it is done. Reverse items, unused kinds and moves or swaps that are dropped
// never raise busy. A move or a non-adjacent swap runs two link reads, a
// compare step, then four write steps with at most one write per step on
// each link memory; an adjacent swap has three write steps, and a move that
// finds the box already in place ends after the compare with no writes. Init
// writes one entry per cycle, sentinel first; query does a read and a step
// per box along the list. A query result shows on odd_position_sum_o for
// one cycle with valid_o; it cannot be stalled. The box count register is
// written through cfg_valid_i / cfg_ready_o, and should only be written
// while busy is low.
module linked_box_order_engine_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [lbo_pkg::KindW-1:0]  kind_i,
  input  logic [lbo_pkg::CountW-1:0] box_a_i,
  input  logic [lbo_pkg::CountW-1:0] box_b_i,
  output logic                       valid_o,
  output logic [lbo_pkg::SumW-1:0]   odd_position_sum_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lbo_pkg::CountW-1:0] cfg_data_i
);

  localparam int unsigned Depth = lbo_pkg::MaxBoxes + 1;
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned NW = $clog2(lbo_pkg::MaxBoxes + 1);
  localparam int unsigned CW = lbo_pkg::CountW;
  localparam int unsigned SW = lbo_pkg::SumW;

  lbo_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [NW-1:0] size_q, size_d;
  logic          rev_q, rev_d;
  logic [2:0]    kind_q, kind_d;
  logic [AW-1:0] a_q, a_d, b_q, b_d;
  logic [AW-1:0] al_q, al_d, ar_q, ar_d, bl_q, bl_d, br_q, br_d;
  logic [NW:0]   idx_q, idx_d;
  logic [2:0]    wstep_q, wstep_d;
  logic [SW-1:0] sum_q, sum_d;
  logic          odd_q, odd_d;
  logic [AW-1:0] node_q, node_d;

  logic          l_we, r_we;
  logic [AW-1:0] l_wa, r_wa, l_wd, r_wd, l_ra, r_ra;
  logic [AW-1:0] l_rd, r_rd;

  lbo_link_mem #(.Depth(Depth), .Width(AW)) u_left (
    .clk_i(clk_i), .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd),
    .raddr_i(l_ra), .rdata_o(l_rd)
  );
  lbo_link_mem #(.Depth(Depth), .Width(AW)) u_right (
    .clk_i(clk_i), .we_i(r_we), .waddr_i(r_wa), .wdata_i(r_wd),
    .raddr_i(r_ra), .rdata_o(r_rd)
  );

  assign busy = (state_q != lbo_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // move direction after applying the reversed flag
  logic to_right;
  assign to_right = (kind_q == lbo_pkg::KIND_RIGHT) != rev_q;

  logic [NW:0]   n_ext;
  logic [CW:0]   a_ok_w, b_ok_w;
  assign n_ext = {1'b0, size_q};

  // total N(N+1)/2 for even N
  logic [2*NW+1:0] tri_full;
  assign tri_full = ({{(NW+1){1'b0}}, n_ext} * ({{(NW+1){1'b0}}, n_ext} + 1'b1)) >> 1;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    size_d = size_q;
    rev_d = rev_q;
    kind_d = kind_q;
    a_d = a_q; b_d = b_q;
    al_d = al_q; ar_d = ar_q; bl_d = bl_q; br_d = br_q;
    idx_d = idx_q;
    wstep_d = wstep_q;
    sum_d = sum_q;
    odd_d = odd_q;
    node_d = node_q;
    l_we = 1'b0; r_we = 1'b0;
    l_wa = '0; r_wa = '0; l_wd = '0; r_wd = '0;
    l_ra = a_q; r_ra = a_q;
    valid_o = 1'b0;
    odd_position_sum_o = sum_q;
    a_ok_w = '0; b_ok_w = '0;

    if (cfg_valid_i) begin
      count_d = cfg_data_i;
    end

    unique case (state_q)
      lbo_pkg::ST_IDLE: begin
        if (start) begin
          kind_d = kind_i;
          a_d = box_a_i[AW-1:0];
          b_d = box_b_i[AW-1:0];
          a_ok_w = {1'b0, box_a_i};
          b_ok_w = {1'b0, box_b_i};
          case (kind_i) inside
            lbo_pkg::KIND_INIT: begin
              if ({1'b0, count_q} > (CW+1)'(lbo_pkg::MaxBoxes)) begin
                size_d = NW'(lbo_pkg::MaxBoxes);
              end else begin
                size_d = NW'(count_q);
              end
              rev_d = 1'b0;
              idx_d = '0;
              state_d = lbo_pkg::ST_INIT;
            end
            lbo_pkg::KIND_REV: rev_d = ~rev_q;
            lbo_pkg::KIND_QUERY: begin
              sum_d = '0;
              odd_d = 1'b1;
              idx_d = (NW+1)'(1);
              node_d = '0;
              state_d = lbo_pkg::ST_Q_RD;
            end
            lbo_pkg::KIND_LEFT, lbo_pkg::KIND_RIGHT, lbo_pkg::KIND_SWAP: begin
              if (box_a_i != box_b_i && box_a_i != '0 && box_b_i != '0 &&
                  a_ok_w <= (CW+1)'(size_q) && b_ok_w <= (CW+1)'(size_q)) begin
                state_d = lbo_pkg::ST_RD_A;
              end
            end
            default: ;
          endcase
        end
      end
      lbo_pkg::ST_INIT: begin
        // entry idx: left = idx-1, right = idx+1 or 0; sentinel at idx 0
        l_we = 1'b1; r_we = 1'b1;
        l_wa = AW'(idx_q); r_wa = AW'(idx_q);
        if (idx_q == '0) begin
          l_wd = AW'(size_q);
          r_wd = (size_q == '0) ? '0 : AW'(1);
        end else begin
          l_wd = AW'(idx_q - 1'b1);
          r_wd = (idx_q == n_ext) ? '0 : AW'(idx_q + 1'b1);
        end
        if (idx_q == n_ext) begin
          state_d = lbo_pkg::ST_IDLE;
        end
        idx_d = idx_q + 1'b1;
      end
      lbo_pkg::ST_RD_A: begin
        l_ra = a_q; r_ra = a_q;
        state_d = lbo_pkg::ST_RD_B;
      end
      lbo_pkg::ST_RD_B: begin
        l_ra = b_q; r_ra = b_q;
        al_d = l_rd; ar_d = r_rd;
        state_d = lbo_pkg::ST_WAIT;
      end
      lbo_pkg::ST_WAIT: begin
        bl_d = l_rd; br_d = r_rd;
        wstep_d = '0;
        state_d = lbo_pkg::ST_WR;
        if (kind_q != lbo_pkg::KIND_SWAP) begin
          if (to_right && r_rd == a_q) state_d = lbo_pkg::ST_IDLE;
          if (!to_right && ar_q == b_q) state_d = lbo_pkg::ST_IDLE;
        end
      end
      lbo_pkg::ST_WR: begin
        // later writes win on an alias; at most one write per memory per step
        wstep_d = wstep_q + 1'b1;
        if (kind_q == lbo_pkg::KIND_SWAP) begin
          if (bl_q == a_q) begin
            case (wstep_q)
              3'd0: begin
                r_we = 1'b1; r_wa = al_q; r_wd = b_q; l_we = 1'b1; l_wa = b_q; l_wd = al_q;
              end
              3'd1: begin
                r_we = 1'b1; r_wa = b_q; r_wd = a_q; l_we = 1'b1; l_wa = a_q; l_wd = b_q;
              end
              default: begin
                r_we = 1'b1; r_wa = a_q; r_wd = br_q; l_we = 1'b1; l_wa = br_q; l_wd = a_q;
                state_d = lbo_pkg::ST_IDLE;
              end
            endcase
          end else if (al_q == b_q) begin
            case (wstep_q)
              3'd0: begin
                r_we = 1'b1; r_wa = bl_q; r_wd = a_q; l_we = 1'b1; l_wa = a_q; l_wd = bl_q;
              end
              3'd1: begin
                r_we = 1'b1; r_wa = a_q; r_wd = b_q; l_we = 1'b1; l_wa = b_q; l_wd = a_q;
              end
              default: begin
                r_we = 1'b1; r_wa = b_q; r_wd = ar_q; l_we = 1'b1; l_wa = ar_q; l_wd = b_q;
                state_d = lbo_pkg::ST_IDLE;
              end
            endcase
          end else begin
            case (wstep_q)
              3'd0: begin
                r_we = 1'b1; r_wa = al_q; r_wd = b_q; l_we = 1'b1; l_wa = ar_q; l_wd = b_q;
              end
              3'd1: begin
                r_we = 1'b1; r_wa = bl_q; r_wd = a_q; l_we = 1'b1; l_wa = br_q; l_wd = a_q;
              end
              3'd2: begin
                l_we = 1'b1; l_wa = a_q; l_wd = bl_q; r_we = 1'b1; r_wa = a_q; r_wd = br_q;
              end
              default: begin
                l_we = 1'b1; l_wa = b_q; l_wd = al_q; r_we = 1'b1; r_wa = b_q; r_wd = ar_q;
                state_d = lbo_pkg::ST_IDLE;
              end
            endcase
          end
        end else if (to_right) begin
          case (wstep_q)
            3'd0: begin
              r_we = 1'b1; r_wa = b_q; r_wd = a_q; l_we = 1'b1; l_wa = a_q; l_wd = b_q;
            end
            3'd1: begin
              r_we = 1'b1; r_wa = a_q; r_wd = br_q; l_we = 1'b1; l_wa = ar_q; l_wd = al_q;
            end
            3'd2: begin r_we = 1'b1; r_wa = al_q; r_wd = ar_q; end
            default: begin
              l_we = 1'b1; l_wa = br_q; l_wd = a_q;
              state_d = lbo_pkg::ST_IDLE;
            end
          endcase
        end else begin
          case (wstep_q)
            3'd0: begin
              r_we = 1'b1; r_wa = a_q; r_wd = b_q; l_we = 1'b1; l_wa = a_q; l_wd = bl_q;
            end
            3'd1: begin
              l_we = 1'b1; l_wa = b_q; l_wd = a_q; r_we = 1'b1; r_wa = al_q; r_wd = ar_q;
            end
            3'd2: begin l_we = 1'b1; l_wa = ar_q; l_wd = al_q; end
            default: begin
              r_we = 1'b1; r_wa = bl_q; r_wd = a_q;
              state_d = lbo_pkg::ST_IDLE;
            end
          endcase
        end
      end
      lbo_pkg::ST_Q_RD: begin
        r_ra = node_q;
        state_d = lbo_pkg::ST_Q_STEP;
      end
      lbo_pkg::ST_Q_STEP: begin
        // r_rd is the next node; idx_q its position
        if (r_rd == '0 || idx_q > n_ext) begin
          state_d = lbo_pkg::ST_Q_FIN;
        end else begin
          if (odd_q) sum_d = sum_q + SW'(r_rd);
          odd_d = ~odd_q;
          idx_d = idx_q + 1'b1;
          node_d = r_rd;
          state_d = lbo_pkg::ST_Q_RD;
        end
      end
      lbo_pkg::ST_Q_FIN: begin
        if (rev_q && !size_q[0]) begin
          odd_position_sum_o = SW'(tri_full) - sum_q;
        end
        valid_o = 1'b1;
        state_d = lbo_pkg::ST_IDLE;
      end
      default: state_d = lbo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lbo_pkg::ST_IDLE;
      count_q <= CW'(1);
      size_q <= '0;
      rev_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      size_q <= size_d;
      rev_q <= rev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    a_q <= a_d; b_q <= b_d;
    al_q <= al_d; ar_q <= ar_d; bl_q <= bl_d; br_q <= br_d;
    idx_q <= idx_d;
    wstep_q <= wstep_d;
    sum_q <= sum_d;
    odd_q <= odd_d;
    node_q <= node_d;
  end

endmodule

>>> rtl/lbo_checker.sv
// ----------------------------------------------------------------------------
// lbo_checker
// Port-level checks on the box order engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbo_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [2:0] kind_i,
  input logic       valid_o
);

  `ASSERT_CLK(a_valid_pulse, clk_i, rst_ni, valid_o |=> !valid_o, "result strobe longer than one cycle")
  `ASSERT_CLK(a_valid_busy, clk_i, rst_ni, valid_o |-> busy, "result outside a busy window")
  `ASSERT_CLK(a_query_busy, clk_i, rst_ni, (start && !busy && kind_i == lbo_pkg::KIND_QUERY) |=> busy, "query did not hold busy")
  `ASSERT_CLK(a_rev_quick, clk_i, rst_ni, (start && !busy && kind_i == lbo_pkg::KIND_REV) |=> !busy, "reverse took more than one cycle")
  `ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !valid_o, "strobe right after reset")

endmodule

bind linked_box_order_engine_unit lbo_checker u_lbo_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .kind_i(kind_i), .valid_o(valid_o)
);

>>> dv/tb_linked_box_order_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linked_box_order_engine_unit
// Drives init, move, swap, reverse, query and unused-kind items plus box count
// writes into the box order engine, keeps its own copy of the link lists, and
// checks every query sum against that copy.
// ----------------------------------------------------------------------------
module tb_linked_box_order_engine_unit;

  localparam int unsigned NBOX     = lbo_pkg::MaxBoxes;
  localparam int unsigned WDOG_LIM = 60000;
  localparam int unsigned SETTLE   = 16;

  typedef struct {
    bit              is_cfg;
    bit              drain;
    logic [2:0]      kind;
    logic [10:0]     box_a;
    logic [10:0]     box_b;
    logic [10:0]     count;
    int unsigned     gap;
  } box_op_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [2:0]       kind_i;
  logic [10:0]      box_a_i;
  logic [10:0]      box_b_i;
  logic             valid_o;
  logic [19:0]      odd_position_sum_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [10:0]      cfg_data_i;

  linked_box_order_engine_unit DUT (.*);

  // shadow of the engine
  int unsigned lft [0:NBOX];
  int unsigned rgt [0:NBOX];
  bit          rev_flag;
  int unsigned list_len;
  int unsigned count_reg;

  box_op_t     pending_ops[$];
  logic [19:0] sum_queue[$];
  int unsigned error_cnt;
  bit          took_item, took_cfg;
  int unsigned idle_cnt;
  int unsigned gap_cnt;
  int unsigned wdog_cnt;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    error_cnt++;
  endtask

  function automatic void build_shadow();
    int unsigned n;
    n = (count_reg > NBOX) ? NBOX : count_reg;
    list_len = n;
    rev_flag = 1'b0;
    for (int i = 0; i <= NBOX; i++) begin
      lft[i] = 0;
      rgt[i] = 0;
    end
    for (int unsigned i = 1; i <= n; i++) begin
      lft[i] = i - 1;
      rgt[i] = (i == n) ? 0 : i + 1;
    end
    rgt[0] = (n == 0) ? 0 : 1;
    lft[0] = n;
  endfunction

  function automatic void swap_shadow(int unsigned a, int unsigned b);
    int unsigned al, ar, bl, br;
    al = lft[a]; ar = rgt[a]; bl = lft[b]; br = rgt[b];
    if (bl == a) begin
      rgt[al] = b; lft[b] = al; rgt[b] = a; lft[a] = b; rgt[a] = br; lft[br] = a;
    end else if (al == b) begin
      rgt[bl] = a; lft[a] = bl; rgt[a] = b; lft[b] = a; rgt[b] = ar; lft[ar] = b;
    end else begin
      rgt[al] = b; lft[ar] = b; rgt[bl] = a; lft[br] = a;
      lft[a] = bl; rgt[a] = br; lft[b] = al; rgt[b] = ar;
    end
  endfunction

  function automatic void move_shadow(int unsigned a, int unsigned b, bit to_right);
    int unsigned al, ar, bl, br;
    al = lft[a]; ar = rgt[a]; bl = lft[b]; br = rgt[b];
    if (to_right) begin
      if (br == a) return;
      rgt[b] = a; lft[a] = b; rgt[a] = br;
      lft[ar] = al; rgt[al] = ar; lft[br] = a;
    end else begin
      if (ar == b) return;
      rgt[a] = b; lft[a] = bl; lft[b] = a;
      rgt[al] = ar; lft[ar] = al; rgt[bl] = a;
    end
  endfunction

  function automatic logic [19:0] odd_sum_shadow();
    longint unsigned acc;
    int unsigned node, pos;
    acc = 0;
    node = rgt[0];
    pos = 1;
    while (node != 0 && node <= NBOX && pos <= list_len) begin
      if (pos[0]) acc += node;
      pos++;
      node = rgt[node];
    end
    if (rev_flag && !list_len[0])
      acc = longint'(list_len) * (list_len + 1) / 2 - acc;
    return acc[19:0];
  endfunction

  // update the shadow for one accepted item; queue a sum for queries
  function automatic void predict_item(logic [2:0] k, int unsigned a, int unsigned b);
    bit ok;
    case (k) inside
      lbo_pkg::KIND_INIT:  build_shadow();
      lbo_pkg::KIND_REV:   rev_flag = ~rev_flag;
      lbo_pkg::KIND_QUERY: sum_queue.push_back(odd_sum_shadow());
      lbo_pkg::KIND_LEFT, lbo_pkg::KIND_RIGHT, lbo_pkg::KIND_SWAP: begin
        ok = a != b && a >= 1 && b >= 1 && a <= list_len && b <= list_len;
        if (ok) begin
          if (k == lbo_pkg::KIND_SWAP) swap_shadow(a, b);
          else move_shadow(a, b, (k == lbo_pkg::KIND_RIGHT) != rev_flag);
        end
      end
      default: ;
    endcase
  endfunction

  // acceptance, prediction and result checking
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      took_item <= 1'b0;
      took_cfg  <= 1'b0;
      idle_cnt  <= 0;
    end else begin
      took_item <= start && !busy;
      took_cfg  <= cfg_valid_i && cfg_ready_o;
      if (cfg_valid_i && cfg_ready_o) count_reg = cfg_data_i;
      if (start && !busy) predict_item(kind_i, box_a_i, box_b_i);
      if (valid_o) begin
        if (sum_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected sum %0d", odd_position_sum_o));
        end else begin
          logic [19:0] want;
          want = sum_queue.pop_front();
          if (odd_position_sum_o !== want)
            report_mismatch($sformatf("odd_position_sum got %0d want %0d",
                                      odd_position_sum_o, want));
        end
      end
      if (busy || start || sum_queue.size() != 0) idle_cnt <= 0;
      else if (idle_cnt < SETTLE) idle_cnt <= idle_cnt + 1;
    end
  end

  // driver: one item or one count write at a time
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start       <= 1'b0;
      cfg_valid_i <= 1'b0;
      kind_i      <= '0;
      box_a_i     <= '0;
      box_b_i     <= '0;
      cfg_data_i  <= '0;
      gap_cnt     <= 0;
    end else begin
      logic    nxt_start, nxt_cfg;
      box_op_t op;
      nxt_start = start && !took_item;
      nxt_cfg   = cfg_valid_i && !took_cfg;
      if (!nxt_start && !nxt_cfg && pending_ops.size() != 0) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
        end else if (!((pending_ops[0].is_cfg || pending_ops[0].drain)
                       && idle_cnt < SETTLE)) begin
          op = pending_ops.pop_front();
          gap_cnt <= op.gap;
          if (op.is_cfg) begin
            nxt_cfg = 1'b1;
            cfg_data_i <= op.count;
          end else begin
            nxt_start = 1'b1;
            kind_i  <= op.kind;
            box_a_i <= op.box_a;
            box_b_i <= op.box_b;
          end
        end
      end
      start       <= nxt_start;
      cfg_valid_i <= nxt_cfg;
    end
  end

  // watchdog on cycles with no handshake or result
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || (cfg_valid_i && cfg_ready_o) || valid_o) begin
      wdog_cnt <= 0;
    end else if (wdog_cnt >= WDOG_LIM) begin
      $display("Verification failed");
      $finish;
    end else begin
      wdog_cnt <= wdog_cnt + 1;
    end
  end

  bit burst_mode;

  function automatic int unsigned draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic void add_item(logic [2:0] k, logic [10:0] a, logic [10:0] b,
                                   bit drain = 1'b0);
    box_op_t op;
    op.is_cfg = 1'b0; op.drain = drain; op.kind = k;
    op.box_a = a; op.box_b = b; op.count = '0; op.gap = draw_gap();
    pending_ops.push_back(op);
  endfunction

  function automatic void add_count(logic [10:0] n);
    box_op_t op;
    op.is_cfg = 1'b1; op.drain = 1'b0; op.kind = '0;
    op.box_a = '0; op.box_b = '0; op.count = n; op.gap = draw_gap();
    pending_ops.push_back(op);
  endfunction

  // mostly legal moves and swaps on the current list, other kinds, some noise
  function automatic void add_random(int unsigned n);
    int unsigned r;
    logic [10:0] a, b;
    r = $urandom_range(0, 99);
    if (n >= 1) begin
      a = 11'($urandom_range(1, n));
      b = 11'($urandom_range(1, n));
    end else begin
      a = 11'($urandom_range(0, 2047));
      b = 11'($urandom_range(0, 2047));
    end
    if (r < 8) begin
      a = 11'($urandom_range(0, 2047));
      b = 11'($urandom_range(0, 2047));
    end
    if (r < 25)      add_item(lbo_pkg::KIND_LEFT, a, b);
    else if (r < 50) add_item(lbo_pkg::KIND_RIGHT, a, b);
    else if (r < 72) add_item(lbo_pkg::KIND_SWAP, a, b);
    else if (r < 81) add_item(lbo_pkg::KIND_REV, a, b);
    else if (r < 95) add_item(lbo_pkg::KIND_QUERY, a, b, $urandom_range(0, 15) == 0);
    else if (r < 97) add_item(3'($urandom_range(6, 7)), a, b);
    else             add_item(lbo_pkg::KIND_INIT, a, b);
  endfunction

  initial begin
    int unsigned n, len;
    rst_ni = 1'b0;
    error_cnt = 0;
    burst_mode = 1'b0;
    count_reg = 1;
    list_len = 0;
    rev_flag = 1'b0;
    for (int i = 0; i <= NBOX; i++) begin
      lft[i] = 0;
      rgt[i] = 0;
    end

    // nothing built yet
    add_item(lbo_pkg::KIND_QUERY, 0, 0);
    add_item(lbo_pkg::KIND_SWAP, 1, 1);
    add_item(lbo_pkg::KIND_LEFT, 1, 2);
    add_item(lbo_pkg::KIND_QUERY, 0, 0);
    // oversized count saturates, full range boxes
    add_count(11'd2047);
    add_item(lbo_pkg::KIND_INIT, 0, 0);
    add_item(lbo_pkg::KIND_QUERY, 0, 0);
    add_item(lbo_pkg::KIND_RIGHT, 11'd1024, 11'd1);
    add_item(lbo_pkg::KIND_SWAP, 11'd2047, 11'd1);
    add_item(lbo_pkg::KIND_LEFT, 11'd0, 11'd5);
    add_item(lbo_pkg::KIND_LEFT, 11'd1025, 11'd5);
    add_item(3'd6, 11'd2047, 11'd2047);
    add_item(3'd7, 11'd3, 11'd4);
    add_item(lbo_pkg::KIND_REV, 0, 0);
    add_item(lbo_pkg::KIND_QUERY, 0, 0, 1'b1);
    // small even list: adjacent swaps, a no-op move, reversed query
    add_count(11'd6);
    add_item(lbo_pkg::KIND_INIT, 0, 0);
    add_item(lbo_pkg::KIND_SWAP, 2, 3);
    add_item(lbo_pkg::KIND_SWAP, 3, 2);
    add_item(lbo_pkg::KIND_LEFT, 1, 3);
    add_item(lbo_pkg::KIND_RIGHT, 4, 3);
    add_item(lbo_pkg::KIND_REV, 0, 0);
    add_item(lbo_pkg::KIND_RIGHT, 6, 1);
    add_item(lbo_pkg::KIND_QUERY, 0, 0);
    // count changed without a new init keeps the old size
    add_count(11'd0);
    add_item(lbo_pkg::KIND_SWAP, 1, 6);
    add_item(lbo_pkg::KIND_QUERY, 0, 0);
    add_item(lbo_pkg::KIND_INIT, 0, 0);
    add_item(lbo_pkg::KIND_QUERY, 0, 0);

    // random phases, mostly small lists
    for (int ph = 0; ph < 90; ph++) begin
      burst_mode = (ph % 4) == 1;
      if (ph % 30 == 29)    n = 1024;
      else if (ph % 30 == 14) n = $urandom_range(1025, 2047);
      else if (ph % 10 == 3)  n = $urandom_range(0, 1);
      else                    n = $urandom_range(2, 13);
      add_count(11'(n));
      add_item(lbo_pkg::KIND_INIT, 0, 0);
      if (n > NBOX) n = NBOX;
      len = (n >= 1024) ? 8 : $urandom_range(12, 25);
      for (int i = 0; i < len; i++) begin
        if (n >= 1024 && $urandom_range(0, 99) < 14) add_item(lbo_pkg::KIND_REV, 0, 0);
        else if (n >= 1024) begin
          logic [10:0] a, b;
          a = 11'($urandom_range(1, n));
          b = 11'($urandom_range(1, n));
          add_item(3'($urandom_range(lbo_pkg::KIND_LEFT, lbo_pkg::KIND_SWAP)), a, b);
        end else add_random(n);
      end
      add_item(lbo_pkg::KIND_QUERY, 0, 0);
    end

    repeat (2) @(posedge clk_i);
    rst_ni = 1'b1;

    wait (pending_ops.size() == 0 && !start && !cfg_valid_i);
    wait (sum_queue.size() == 0 && !busy);
    repeat (40) @(posedge clk_i);
    if (error_cnt == 0 && sum_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
